// ===== hdl/daubechies_wavelet_line_transform_top_defines.svh =====
// assertion helpers
`ifndef DAUBECHIES_WAVELET_LINE_TRANSFORM_TOP_DEFINES_SVH
`define DAUBECHIES_WAVELET_LINE_TRANSFORM_TOP_DEFINES_SVH
`ifndef SYNTH
`define ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("assertion failed");
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("assertion failed");
`else
`define ASSERT_IMPL(label, ante, cons)
`define ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== hdl/dwlt_pkg.sv =====
`default_nettype none
package dwlt_pkg;
	localparam int MAX_PAIRS = 512;
	localparam int HIST = 3;
	localparam int QDEPTH = 4;
	typedef logic signed [15:0] smp_t;
	typedef struct packed {
		smp_t a_re;
		smp_t a_im;
		smp_t b_re;
		smp_t b_im;
	} pair_t;
	// one job for the back end: window (oldest first), config, position info
	typedef struct packed {
		pair_t [6:0] win;
		logic inv;
		logic [1:0] sel;
		logic [2:0] base;
		logic [8:0] pos;
		logic last;
	} job_t;
	typedef struct packed {
		logic signed [17:0] a_re;
		logic signed [17:0] a_im;
		logic signed [17:0] b_re;
		logic signed [17:0] b_im;
		logic [8:0] pos;
		logic last;
	} res_t;
	function automatic logic signed [15:0] coef(input logic [1:0] sel, input int idx);
		logic signed [15:0] t [3][8];
		t[0] = '{16'sd15826, 16'sd27411, 16'sd7345, -16'sd4240, 16'sd0, 16'sd0, 16'sd0, 16'sd0};
		t[1] = '{16'sd10901, 16'sd26440, 16'sd15069, -16'sd4424, -16'sd2800, 16'sd1154,
			16'sd0, 16'sd0};
		t[2] = '{16'sd7549, 16'sd23424, 16'sd20673, -16'sd917, -16'sd6129, 16'sd1011,
			16'sd1078, -16'sd347};
		if (idx < 0 || idx > 7) return 16'sd0;
		return t[(sel >= 2'd2) ? 2 : int'(sel)][idx];
	endfunction
endpackage
`default_nettype wire

// ===== hdl/dwlt_front.sv =====
`default_nettype none
module dwlt_front (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire dwlt_pkg::pair_t in_pair,
	input wire logic in_eol,
	input wire logic inverse_mode,
	input wire logic [1:0] filter_length_select,
	output logic job_valid,
	input wire logic job_ready,
	output dwlt_pkg::job_t job
);
	import dwlt_pkg::*;
	pair_t [HIST-1:0] hist_q;
	logic [8:0] cnt_q;
	logic [1:0] fill_q;
	// flush state: remaining back index on the last pair
	logic busy_q;
	logic [1:0] back_q;
	pair_t [6:0] fwin_q;
	logic [1:0] fsel_q;
	logic [8:0] fcnt_q;
	logic [1:0] half_m1, lag, nback;
	logic emit_now, acc;
	pair_t [6:0] win_now;

	always_comb begin
		half_m1 = (filter_length_select == 2'd0) ? 2'd1 :
			(filter_length_select == 2'd1) ? 2'd2 : 2'd3;
		lag = (fill_q < half_m1) ? fill_q : half_m1;
		win_now = '0;
		win_now[0] = hist_q[0];
		win_now[1] = hist_q[1];
		win_now[2] = hist_q[2];
		win_now[3] = in_pair;
		in_ready = !busy_q && job_ready;
		acc = in_valid && in_ready;
		emit_now = inverse_mode || in_eol || (lag == half_m1);
		nback = (inverse_mode || !in_eol) ? (inverse_mode ? 2'd0 : half_m1) : lag;
		job_valid = busy_q || (in_valid && !busy_q && emit_now);
		job = '0;
		if (busy_q) begin
			job.win = fwin_q;
			job.inv = 1'b0;
			job.sel = fsel_q;
			job.base = 3'(3 - back_q);
			job.pos = 9'(fcnt_q - 9'(back_q));
			job.last = back_q == 2'd0;
		end else begin
			job.win = win_now;
			job.inv = inverse_mode;
			job.sel = filter_length_select;
			job.base = 3'(3 - nback);
			job.pos = inverse_mode ? cnt_q : 9'(cnt_q - 9'(nback));
			job.last = in_eol && (inverse_mode || nback == 2'd0);
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			fwin_q <= win_now;
			fsel_q <= filter_length_select;
			fcnt_q <= cnt_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q <= '0;
			cnt_q <= '0;
			fill_q <= '0;
			busy_q <= 1'b0;
			back_q <= '0;
		end else begin
			if (busy_q && job_ready) begin
				back_q <= back_q - 2'd1;
				if (back_q == 2'd0) busy_q <= 1'b0;
			end
			if (acc) begin
				if (in_eol) begin
					hist_q <= '0;
					cnt_q <= '0;
					fill_q <= '0;
					if (!inverse_mode && nback != 2'd0) begin
						busy_q <= 1'b1;
						back_q <= nback - 2'd1;
					end
				end else begin
					hist_q[0] <= hist_q[1];
					hist_q[1] <= hist_q[2];
					hist_q[2] <= in_pair;
					cnt_q <= cnt_q + 9'd1;
					if (fill_q < 2'(HIST)) fill_q <= fill_q + 2'd1;
				end
			end
		end
	end
endmodule
`default_nettype wire

// ===== hdl/dwlt_queue.sv =====
`default_nettype none
`include "daubechies_wavelet_line_transform_top_defines.svh"
module dwlt_queue (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic wr_valid,
	output logic wr_ready,
	input wire dwlt_pkg::job_t wr_data,
	output logic rd_valid,
	input wire logic rd_ready,
	output dwlt_pkg::job_t rd_data
);
	import dwlt_pkg::*;
	job_t mem_q [QDEPTH];
	logic [1:0] wp_q, rp_q;
	logic [2:0] cnt_q;
	logic wr, rd;
	assign wr_ready = cnt_q != 3'(QDEPTH);
	assign rd_valid = cnt_q != 3'd0;
	assign rd_data = mem_q[rp_q];
	assign wr = wr_valid && wr_ready;
	assign rd = rd_valid && rd_ready;
	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wr_data;
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= wp_q + 2'd1;
			if (rd) rp_q <= rp_q + 2'd1;
			cnt_q <= cnt_q + 3'(wr) - 3'(rd);
		end
	end
	`ASSERT_IMPL(a_q_bound, 1'b1, cnt_q <= 3'(QDEPTH))
	`ASSERT_NEXT(a_q_full, wr && !rd && cnt_q == 3'(QDEPTH - 1), !wr_ready)
	`ASSERT_NEXT(a_q_empty, rd && !wr && cnt_q == 3'd1, !rd_valid)
endmodule
`default_nettype wire

// ===== hdl/dwlt_back.sv =====
`default_nettype none
module dwlt_back (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic job_valid,
	output logic job_ready,
	input wire dwlt_pkg::job_t job,
	output logic res_valid,
	input wire logic res_ready,
	output dwlt_pkg::res_t res
);
	import dwlt_pkg::*;
	// stage 1: products, stage 2: sums, stage 3: round/sat
	logic signed [31:0] p_s1 [4][4][2];
	logic v_s1, v_s2, v_s3;
	logic [9:0] info_s1, info_s2;
	logic signed [35:0] sum_s2 [4];
	res_t res_s3;
	logic adv;
	assign adv = !v_s3 || res_ready;
	assign job_ready = adv;
	assign res_valid = v_s3;
	assign res = res_s3;

	function automatic logic signed [17:0] rsat(input logic signed [35:0] s);
		logic signed [35:0] q;
		q = (s + 36'sd16384) >>> 15;
		if (q > 36'sd131071) return 18'sd131071;
		if (q < -36'sd131072) return -18'sd131072;
		return q[17:0];
	endfunction

	always_ff @(posedge clk) begin
		int taps;
		pair_t pp;
		taps = 4 + 2 * ((job.sel >= 2'd2) ? 2 : int'(job.sel));
		if (adv) begin
			for (int k = 0; k < 4; k++) begin
				if (job.inv) pp = job.win[3 - k];
				else pp = job.win[int'(job.base) + k];
				if (2 * k >= taps) pp = '0;
				// c: 0 re, 1 im; lanes 0,1 form out a, lanes 2,3 out b
				p_s1[k][0][0] <= pp.a_re * coef(job.sel, job.inv ? 2*k : 2*k);
				p_s1[k][0][1] <= pp.a_im * coef(job.sel, 2*k);
				p_s1[k][1][0] <= pp.b_re * (job.inv ? coef(job.sel, taps-1-2*k)
					: coef(job.sel, 2*k+1));
				p_s1[k][1][1] <= pp.b_im * (job.inv ? coef(job.sel, taps-1-2*k)
					: coef(job.sel, 2*k+1));
				p_s1[k][2][0] <= pp.a_re * (job.inv ? coef(job.sel, 2*k+1)
					: coef(job.sel, taps-1-2*k));
				p_s1[k][2][1] <= pp.a_im * (job.inv ? coef(job.sel, 2*k+1)
					: coef(job.sel, taps-1-2*k));
				p_s1[k][3][0] <= pp.b_re * coef(job.sel, taps-2-2*k);
				p_s1[k][3][1] <= pp.b_im * coef(job.sel, taps-2-2*k);
			end
			info_s1 <= {job.pos, job.last};
			for (int c = 0; c < 2; c++) begin
				sum_s2[c] <= 36'(p_s1[0][0][c]) + 36'(p_s1[0][1][c]) + 36'(p_s1[1][0][c])
					+ 36'(p_s1[1][1][c]) + 36'(p_s1[2][0][c]) + 36'(p_s1[2][1][c])
					+ 36'(p_s1[3][0][c]) + 36'(p_s1[3][1][c]);
				sum_s2[2+c] <= 36'(p_s1[0][2][c]) - 36'(p_s1[0][3][c]) + 36'(p_s1[1][2][c])
					- 36'(p_s1[1][3][c]) + 36'(p_s1[2][2][c]) - 36'(p_s1[2][3][c])
					+ 36'(p_s1[3][2][c]) - 36'(p_s1[3][3][c]);
			end
			info_s2 <= info_s1;
			res_s3.a_re <= rsat(sum_s2[0]);
			res_s3.a_im <= rsat(sum_s2[1]);
			res_s3.b_re <= rsat(sum_s2[2]);
			res_s3.b_im <= rsat(sum_s2[3]);
			res_s3.pos <= info_s2[9:1];
			res_s3.last <= info_s2[0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= job_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end
endmodule
`default_nettype wire

// ===== hdl/daubechies_wavelet_line_transform_top.sv =====
`default_nettype none
// path: each job is written into the queue, then passes the 3 back-end stages
// the flush jobs of a forward line end enter the queue one per cycle while it has room
// throughput: one pair per cycle while the queue has room; the last pair of a forward line adds
// up to 3 flush results, during which the front end holds off new input
// reset: arst_n clears history, counters, queue and pipeline valids asynchronously
`include "daubechies_wavelet_line_transform_top_defines.svh"
module daubechies_wavelet_line_transform_top (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_axis_tvalid,
	output logic s_axis_tready,
	input wire logic [63:0] s_axis_tdata, // first_re, first_im, second_re, second_im
	input wire logic s_axis_tlast,
	output logic m_axis_tvalid,
	input wire logic m_axis_tready,
	output logic [87:0] m_axis_tdata, // out_a_re, out_a_im, out_b_re, out_b_im, position
	output logic m_axis_tlast,
	input wire logic cfg_we,
	input wire logic cfg_index,
	input wire logic [1:0] cfg_wdata
);
	import dwlt_pkg::*;
	logic inv_q;
	logic [1:0] sel_q;
	pair_t inp;
	job_t fj, qj;
	logic fv, fr, qv, qr;
	res_t r;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_q <= 1'b0;
			sel_q <= 2'd0;
		end else if (cfg_we) begin
			if (cfg_index == 1'b0) inv_q <= cfg_wdata[0];
			else sel_q <= cfg_wdata;
		end
	end
	assign inp.a_re = s_axis_tdata[15:0];
	assign inp.a_im = s_axis_tdata[31:16];
	assign inp.b_re = s_axis_tdata[47:32];
	assign inp.b_im = s_axis_tdata[63:48];
	dwlt_front u_front (.clk, .arst_n, .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.in_pair(inp), .in_eol(s_axis_tlast), .inverse_mode(inv_q),
		.filter_length_select(sel_q), .job_valid(fv), .job_ready(fr), .job(fj));
	dwlt_queue u_queue (.clk, .arst_n, .wr_valid(fv), .wr_ready(fr), .wr_data(fj),
		.rd_valid(qv), .rd_ready(qr), .rd_data(qj));
	dwlt_back u_back (.clk, .arst_n, .job_valid(qv), .job_ready(qr), .job(qj),
		.res_valid(m_axis_tvalid), .res_ready(m_axis_tready), .res(r));
	assign m_axis_tdata = {7'd0, r.pos, r.b_im, r.b_re, r.a_im, r.a_re};
	assign m_axis_tlast = r.last;
	`ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
	`ASSERT_IMPL(a_tdata_pad, 1'b1, m_axis_tdata[87:81] == 7'd0)
	`ASSERT_NEXT(a_out_stable, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))
endmodule
`default_nettype wire
